### src/khr_pkg.sv
`default_nettype none

package khr_pkg;

    localparam int NUM_KEYS_DEF = 3;

    localparam int COUNT_W = 8;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

    localparam int THRESH_W = 8;
    localparam logic [THRESH_W-1:0] HOLD_RESET = 8'd10;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_MODE = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HOLD_THRESHOLD = 8'd1;

    typedef enum logic [1:0] {
        CHG_NONE    = 2'd0,
        CHG_PRESS   = 2'd1,
        CHG_RELEASE = 2'd2
    } change_kind_t;

endpackage

`default_nettype wire

### src/key_hold_repeat_detector.sv
// key_hold_repeat_detector
//
// Each input beat on in_valid/in_ready is one poll tick carrying pin_levels,
// one active-low bit per key. Every tick yields exactly one output beat on
// out_valid/out_ready with report_valid/report_key (long press or repeat)
// and change_kind/change_key (press or release edge seen this tick).
// Configuration writes arrive on cfg_valid/cfg_ready with cfg_index and
// cfg_data: index 0 is repeat_mode, index 1 is hold_threshold; other indexes
// are ignored. cfg_ready is always high; write only while the block is idle.
// An input beat passes through the input register, then the per-key priority
// logic feeding the output register, where the key state is updated as well.
// One tick is accepted every cycle while the receiver does not stall.
// When the receiver stalls, the result waits in the output register and one
// more tick can wait in the input register; after that in_ready drops.
// Reset releases all keys, clears hold counts, sets repeat_mode to 0 and
// hold_threshold to 10, and empties both registers.
`default_nettype none

module key_hold_repeat_detector #(
    parameter int NUM_KEYS = khr_pkg::NUM_KEYS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic [NUM_KEYS-1:0]                  pin_levels,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic                                      report_valid,
    output logic [((NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1)-1:0] report_key,
    output logic [1:0]                                change_kind,
    output logic [((NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1)-1:0] change_key,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [khr_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire logic [khr_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int KEY_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

    logic                                        repeat_mode_reg;
    logic [khr_pkg::THRESH_W-1:0]                threshold_reg;
    logic                                        s1_valid_reg;
    logic [NUM_KEYS-1:0]                         s1_pins_reg;
    logic [NUM_KEYS-1:0]                         flags_reg;
    logic [NUM_KEYS-1:0]                         flags_next;
    logic [NUM_KEYS-1:0][khr_pkg::COUNT_W-1:0]   counts_reg;
    logic [NUM_KEYS-1:0][khr_pkg::COUNT_W-1:0]   counts_next;
    logic                                        out_valid_reg;
    logic                                        report_valid_reg;
    logic                                        report_valid_next;
    logic [KEY_W-1:0]                            report_key_reg;
    logic [KEY_W-1:0]                            report_key_next;
    khr_pkg::change_kind_t                       change_kind_reg;
    khr_pkg::change_kind_t                       change_kind_next;
    logic [KEY_W-1:0]                            change_key_reg;
    logic [KEY_W-1:0]                            change_key_next;
    logic                                        s1_fire;
    logic                                        cfg_fire;

    assign s1_fire  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_fire;
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    khr_eval #(
        .NUM_KEYS(NUM_KEYS)
    ) u_eval (
        .pins         (s1_pins_reg),
        .flags        (flags_reg),
        .counts       (counts_reg),
        .repeat_mode  (repeat_mode_reg),
        .threshold    (threshold_reg),
        .flags_next   (flags_next),
        .counts_next  (counts_next),
        .report_valid (report_valid_next),
        .report_key   (report_key_next),
        .change_kind  (change_kind_next),
        .change_key   (change_key_next)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            repeat_mode_reg <= 1'b0;
            threshold_reg   <= khr_pkg::HOLD_RESET;
        end
        else if (cfg_fire)
        begin
            unique case (cfg_index)
                khr_pkg::REG_REPEAT_MODE:    repeat_mode_reg <= cfg_data[0];
                khr_pkg::REG_HOLD_THRESHOLD: threshold_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_pins_reg <= pin_levels;
        end
    end

    // key state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg  <= '0;
            counts_reg <= '0;
        end
        else if (s1_fire)
        begin
            flags_reg  <= flags_next;
            counts_reg <= counts_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            report_valid_reg <= report_valid_next;
            report_key_reg   <= report_key_next;
            change_kind_reg  <= change_kind_next;
            change_key_reg   <= change_key_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign report_valid = report_valid_reg;
    assign report_key   = report_key_reg;
    assign change_kind  = change_kind_reg;
    assign change_key   = change_key_reg;

endmodule

`default_nettype wire

### src/khr_eval.sv
`default_nettype none

module khr_eval #(
    parameter int NUM_KEYS = khr_pkg::NUM_KEYS_DEF
) (
    input  wire logic [NUM_KEYS-1:0]                         pins,
    input  wire logic [NUM_KEYS-1:0]                         flags,
    input  wire logic [NUM_KEYS-1:0][khr_pkg::COUNT_W-1:0]   counts,
    input  wire logic                                        repeat_mode,
    input  wire logic [khr_pkg::THRESH_W-1:0]                threshold,
    output logic      [NUM_KEYS-1:0]                         flags_next,
    output logic      [NUM_KEYS-1:0][khr_pkg::COUNT_W-1:0]   counts_next,
    output logic                                             report_valid,
    output logic      [((NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1)-1:0] report_key,
    output khr_pkg::change_kind_t                            change_kind,
    output logic      [((NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1)-1:0] change_key
);

    localparam int KEY_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

    always_comb
    begin
        logic [NUM_KEYS-1:0] diff;
        logic [NUM_KEYS-1:0][khr_pkg::COUNT_W-1:0] counts_t;
        logic [khr_pkg::COUNT_W-1:0] inc;
        logic found;
        logic done;
        logic stop;

        diff         = ~(flags ^ pins);
        found        = 1'b0;
        done         = 1'b0;
        stop         = 1'b0;
        inc          = '0;
        flags_next   = flags;
        counts_t     = counts;
        report_valid = 1'b0;
        report_key   = '0;
        change_kind  = khr_pkg::CHG_NONE;
        change_key   = '0;

        // lowest key whose inverted pin disagrees with its flag toggles
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            if (diff[k] && !found)
            begin
                found         = 1'b1;
                flags_next[k] = ~flags[k];
                change_key    = KEY_W'(k);
                if (!flags[k])
                begin
                    change_kind = khr_pkg::CHG_PRESS;
                    counts_t[k] = '0;
                end
                else
                begin
                    change_kind = khr_pkg::CHG_RELEASE;
                    if (!repeat_mode && (counts[k] >= threshold))
                    begin
                        report_valid = 1'b1;
                        report_key   = KEY_W'(k);
                        done         = 1'b1;
                    end
                end
            end
        end

        counts_next = counts_t;

        // held keys count up unless a release was reported; in repeat mode the first to qualify stops the rest
        if (!done)
        begin
            for (int k = 0; k < NUM_KEYS; k++)
            begin
                if (flags_next[k] && !stop)
                begin
                    inc = (counts_t[k] == khr_pkg::COUNT_MAX) ? counts_t[k]
                                                              : counts_t[k] + 8'd1;
                    counts_next[k] = inc;
                    if (repeat_mode && (inc >= threshold))
                    begin
                        counts_next[k] = '0;
                        report_valid   = 1'b1;
                        report_key     = KEY_W'(k);
                        stop           = 1'b1;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

### verif/key_hold_repeat_detector_tb.sv
module key_hold_repeat_detector_tb;

    localparam int KEYS = khr_pkg::NUM_KEYS_DEF;
    localparam int IDX_W = khr_pkg::CFG_INDEX_W;
    localparam int DATA_W = khr_pkg::CFG_DATA_W;
    localparam int CNT_W = khr_pkg::COUNT_W;
    localparam int THR_W = khr_pkg::THRESH_W;
    localparam int RANDOM_TICKS = 700;
    localparam int QUIET_TICKS = 200;
    localparam int PHASE_TICKS = 120;

    typedef struct packed {
        logic                  report_valid;
        logic [1:0]            report_key;
        khr_pkg::change_kind_t change_kind;
        logic [1:0]            change_key;
    } tick_result_t;

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic [KEYS-1:0] pin_levels;
    logic out_valid;
    logic out_ready;
    logic report_valid;
    logic [1:0] report_key;
    logic [1:0] change_kind;
    logic [1:0] change_key;
    logic cfg_valid;
    logic cfg_ready;
    logic [IDX_W-1:0] cfg_index;
    logic [DATA_W-1:0] cfg_data;

    // keypad state mirrored by the predictor
    logic             key_down [KEYS];
    logic [CNT_W-1:0] hold_cnt [KEYS];
    logic             repeat_on;
    logic [THR_W-1:0] hold_thr;

    tick_result_t pending_results [$];
    int mismatch_count = 0;
    bit idle_on = 1'b1;

    key_hold_repeat_detector #(
        .NUM_KEYS(KEYS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .pin_levels(pin_levels),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .report_valid(report_valid),
        .report_key(report_key),
        .change_kind(change_kind),
        .change_key(change_key),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #4 clk = ~clk;

    function automatic tick_result_t advance_keypad(input logic [KEYS-1:0] pins);
        tick_result_t r;
        bit found;
        bit done;
        int k;
        r = '0;
        found = 1'b0;
        done = 1'b0;
        for (k = 0; k < KEYS; k++)
        begin
            if (!found && key_down[k] == pins[k])
            begin
                found = 1'b1;
                key_down[k] = ~key_down[k];
                r.change_key = k[1:0];
                if (key_down[k])
                begin
                    r.change_kind = khr_pkg::CHG_PRESS;
                    hold_cnt[k] = '0;
                end
                else
                begin
                    r.change_kind = khr_pkg::CHG_RELEASE;
                    if (!repeat_on && hold_cnt[k] >= hold_thr)
                    begin
                        r.report_valid = 1'b1;
                        r.report_key = k[1:0];
                        done = 1'b1;
                    end
                end
            end
        end
        if (!done)
        begin
            for (k = 0; k < KEYS; k++)
            begin
                if (!done && key_down[k])
                begin
                    if (hold_cnt[k] != khr_pkg::COUNT_MAX)
                        hold_cnt[k] = hold_cnt[k] + 8'd1;
                    if (repeat_on && hold_cnt[k] >= hold_thr)
                    begin
                        hold_cnt[k] = '0;
                        r.report_valid = 1'b1;
                        r.report_key = k[1:0];
                        done = 1'b1;
                    end
                end
            end
        end
        return r;
    endfunction

    // called at a falling edge, returns at the falling edge after the beat
    task automatic send_tick(input logic [KEYS-1:0] pins);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 17);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        pin_levels <= pins;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        pending_results.push_back(advance_keypad(pins));
        @(negedge clk);
    endtask

    task automatic hold_pins(input logic [KEYS-1:0] pins, input int ticks);
        int i;
        for (i = 0; i < ticks; i++)
            send_tick(pins);
    endtask

    // stop the stream and let every outstanding tick come back
    task automatic settle_block();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx,
                             input logic [DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            khr_pkg::REG_REPEAT_MODE:    repeat_on = data[0];
            khr_pkg::REG_HOLD_THRESHOLD: hold_thr = data;
            default:                     ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // upper data bits are junk on purpose, only bit 0 counts
    task automatic set_mode(input logic mode, input logic [THR_W-1:0] thr);
        logic [DATA_W-1:0] word;
        settle_block();
        word = DATA_W'($urandom);
        word[0] = mode;
        write_reg(khr_pkg::REG_REPEAT_MODE, word);
        write_reg(khr_pkg::REG_HOLD_THRESHOLD, thr);
    endtask

    task automatic check_field(input string what, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0d got %0d", $time, what, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        tick_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: expected no beat got report %0d/%0d change %0d/%0d",
                         $time, report_valid, report_key, change_kind, change_key);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("report_valid", 8'(want.report_valid), 8'(report_valid));
                check_field("report_key", 8'(want.report_key), 8'(report_key));
                check_field("change_kind", 8'(want.change_kind), 8'(change_kind));
                check_field("change_key", 8'(want.change_key), 8'(change_key));
            end
        end
    end

    initial
    begin : sink_pacing
        int stall_left;
        stall_left = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left == 0 && idle_on && rst_n && $urandom_range(0, 11) == 0)
                stall_left = $urandom_range(1, 17);
            if (stall_left > 0 && idle_on)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic test_default_release();
        hold_pins(3'b110, 12);
        hold_pins(3'b111, 1);
        hold_pins(3'b101, 5);
        hold_pins(3'b111, 2);
    endtask

    task automatic test_toggle_priority();
        hold_pins(3'b000, 4);
        hold_pins(3'b111, 4);
        hold_pins(3'b010, 3);
        hold_pins(3'b101, 4);
        hold_pins(3'b111, 3);
    endtask

    task automatic test_repeat_mode();
        set_mode(1'b1, 8'd3);
        hold_pins(3'b000, 16);
        hold_pins(3'b001, 6);
        hold_pins(3'b111, 4);
    endtask

    task automatic test_threshold_extremes();
        set_mode(1'b0, 8'd1);
        hold_pins(3'b011, 2);
        hold_pins(3'b111, 1);
        // zero threshold: any hold qualifies
        set_mode(1'b0, 8'd0);
        hold_pins(3'b101, 1);
        hold_pins(3'b111, 1);
        set_mode(1'b1, 8'd0);
        hold_pins(3'b100, 6);
        hold_pins(3'b111, 3);
        set_mode(1'b1, khr_pkg::COUNT_MAX);
        hold_pins(3'b110, 258);
        hold_pins(3'b111, 1);
    endtask

    task automatic test_counter_saturation();
        set_mode(1'b0, khr_pkg::COUNT_MAX);
        hold_pins(3'b011, 300);
        hold_pins(3'b111, 1);
    endtask

    task automatic test_ignored_writes();
        int i;
        settle_block();
        for (i = 0; i < 6; i++)
            write_reg(IDX_W'($urandom_range(2, 255)), DATA_W'($urandom));
        write_reg(IDX_W'($urandom_range(128, 255)), DATA_W'($urandom));
        hold_pins(3'b010, 8);
        hold_pins(3'b111, 2);
        set_mode(1'b0, 8'd4);
        hold_pins(3'b100, 6);
        hold_pins(3'b111, 3);
    endtask

    task automatic test_random_traffic();
        int sent;
        int in_phase;
        int run;
        int lim;
        int sel;
        logic [KEYS-1:0] pins;
        logic [THR_W-1:0] thr;
        sent = 0;
        while (sent < RANDOM_TICKS)
        begin
            sel = $urandom_range(0, 9);
            if (sel == 0)
                thr = '0;
            else if (sel == 1)
                thr = khr_pkg::COUNT_MAX;
            else if (sel <= 7)
                thr = THR_W'($urandom_range(1, 12));
            else
                thr = THR_W'($urandom_range(1, 254));
            set_mode(1'($urandom_range(0, 1)), thr);
            in_phase = 0;
            while (in_phase < PHASE_TICKS && sent < RANDOM_TICKS)
            begin
                if (sent >= RANDOM_TICKS - QUIET_TICKS)
                    idle_on = 1'b0;
                pins = KEYS'($urandom_range(0, 7));
                if ($urandom_range(0, 4) == 0)
                begin
                    run = 1;
                end
                else
                begin
                    lim = int'(hold_thr) + 6;
                    if (lim > 40 && $urandom_range(0, 7) != 0)
                        lim = 40;
                    run = $urandom_range(1, lim);
                end
                hold_pins(pins, run);
                sent += run;
                in_phase += run;
            end
        end
    endtask

    initial
    begin
        in_valid = 1'b0;
        pin_levels = '1;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        rst_n = 1'b0;
        for (int k = 0; k < KEYS; k++)
        begin
            key_down[k] = 1'b0;
            hold_cnt[k] = '0;
        end
        repeat_on = 1'b0;
        hold_thr = khr_pkg::HOLD_RESET;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_default_release();
        test_toggle_priority();
        test_repeat_mode();
        test_threshold_extremes();
        test_counter_saturation();
        test_ignored_writes();
        test_random_traffic();

        settle_block();
        repeat (8) @(negedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("key_hold_repeat_detector_tb: clean");
        else
            $display("key_hold_repeat_detector_tb: errors");
        $finish;
    end

    initial
    begin
        #6000000;
        $display("key_hold_repeat_detector_tb: errors");
        $finish;
    end

endmodule
